// File: sv/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants of the grid collision detector
// Grid geometry, item and result layouts, memory entry format and helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Grid geometry and field widths
  localparam int unsigned GridX     = 16;
  localparam int unsigned GridY     = 16;
  localparam int unsigned GridZ     = 16;
  localparam int unsigned MaxDrones = 255;
  localparam int unsigned Cells     = GridX * GridY * GridZ;
  localparam int unsigned CellAw    = $clog2(Cells);
  localparam int unsigned IdW       = 8;
  localparam int unsigned CoordW    = 4;
  localparam int unsigned CountW    = 16;
  localparam int unsigned EpochW    = 8;
  localparam int unsigned EntryW    = EpochW + IdW;

  localparam logic [CountW-1:0] LimitReset = 16'd10;
  localparam logic [CountW-1:0] CountMax   = '1;

  // Item kinds carried on tuser
  localparam logic CmdReport   = 1'b0;
  localparam logic CmdFrameEnd = 1'b1;

  typedef enum logic {
    StSweep,
    StRun
  } state_e;

  typedef struct packed {
    logic              command;
    logic [IdW-1:0]    drone_id;
    logic              has_position;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic              collision;
    logic [IdW-1:0]    other_drone;
    logic [CountW-1:0] collision_count;
    logic              halted;
  } res_t;

  // One grid cell: frame tag plus owner id (owner 0 = empty)
  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [IdW-1:0]    owner;
  } entry_t;

  // Status from the update stage toward the input handshake
  typedef struct packed {
    logic s1_valid;
    logic block;
  } stat_t;

  // Linear cell address of a coordinate triple
  function automatic logic [CellAw-1:0] cell_index(logic [CoordW-1:0] x,
                                                   logic [CoordW-1:0] y,
                                                   logic [CoordW-1:0] z);
    int unsigned idx;
    idx = (int'(x) * GridY + int'(y)) * GridZ + int'(z);
    return idx[CellAw-1:0];
  endfunction

  // Coordinates inside the grid
  function automatic logic in_grid(logic [CoordW-1:0] x,
                                   logic [CoordW-1:0] y,
                                   logic [CoordW-1:0] z);
    return (int'(x) < GridX) && (int'(y) < GridY) && (int'(z) < GridZ);
  endfunction

endpackage

// File: sv/gcd_ram.sv
// ----------------------------------------------------------------------------
// gcd_ram: generic single-clock RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module gcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/gcd_rmw.sv
// ----------------------------------------------------------------------------
// gcd_rmw: grid read-modify-write stage
// Reads the cell on accept, resolves occupancy in the following cycle with forwarding,
// keeps frame tag, collision count and halt flag, and sweeps the grid clear.
// ----------------------------------------------------------------------------
module gcd_rmw (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  gcd_pkg::item_t             item_i,
  input  logic [gcd_pkg::CountW-1:0] limit_i,
  output logic                       res_valid_o,
  output gcd_pkg::res_t              res_o,
  output gcd_pkg::stat_t             stat_o
);

  gcd_pkg::state_e                   state_q, state_d;
  logic [gcd_pkg::CellAw-1:0]        sweep_addr_q;
  logic                              s1_valid_q;
  gcd_pkg::item_t                    s1_item_q;
  logic [gcd_pkg::CellAw-1:0]        s1_addr_q;
  logic [gcd_pkg::EpochW-1:0]        epoch_q, epoch_d;
  logic [gcd_pkg::CountW-1:0]        count_q, count_d, count_inc;
  logic                              halt_q, halt_d;
  logic                              fwd_valid_q;
  logic [gcd_pkg::CellAw-1:0]        fwd_addr_q;
  gcd_pkg::entry_t                   fwd_data_q;

  logic [gcd_pkg::CellAw-1:0]        raddr;
  gcd_pkg::entry_t                   rdata, cur, wdata_upd, ram_wdata;
  logic [gcd_pkg::IdW-1:0]           owner;
  logic                              pos_ok, hit, upd_we, wrap, sweep_last;
  logic                              ram_we;
  logic [gcd_pkg::CellAw-1:0]        ram_waddr;

  assign raddr = gcd_pkg::cell_index(item_i.pos_x, item_i.pos_y, item_i.pos_z);

  gcd_ram #(
    .Width(gcd_pkg::EntryW),
    .Depth(gcd_pkg::Cells)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Resolve the cell owner: forward last write, entries of old frames are empty
  always_comb begin
    cur   = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata;
    owner = (cur.epoch == epoch_q) ? cur.owner : '0;
    pos_ok = s1_item_q.has_position
          && (32'(s1_item_q.drone_id) <= gcd_pkg::MaxDrones)
          && gcd_pkg::in_grid(s1_item_q.pos_x, s1_item_q.pos_y, s1_item_q.pos_z);
    hit       = (owner != '0) && (owner != s1_item_q.drone_id);
    count_inc = (count_q == gcd_pkg::CountMax) ? count_q : count_q + 1'b1;
    wdata_upd = '{epoch: epoch_q, owner: s1_item_q.drone_id};
  end

  // Decide the item in the update stage
  always_comb begin
    epoch_d = epoch_q;
    count_d = count_q;
    halt_d  = halt_q;
    upd_we  = 1'b0;
    wrap    = 1'b0;
    res_o   = '{collision: 1'b0, other_drone: '0, collision_count: count_q,
                halted: halt_q};
    if (s1_valid_q && !halt_q) begin
      if (s1_item_q.command == gcd_pkg::CmdFrameEnd) begin
        if (epoch_q == '1) begin
          wrap    = 1'b1;
          epoch_d = '0;
        end else begin
          epoch_d = epoch_q + 1'b1;
        end
      end else if (pos_ok) begin
        if (hit) begin
          count_d = count_inc;
          halt_d  = (count_inc >= limit_i);
          res_o   = '{collision: 1'b1, other_drone: owner,
                      collision_count: count_inc, halted: (count_inc >= limit_i)};
        end else begin
          upd_we = 1'b1;
        end
      end
    end
  end

  assign res_valid_o = s1_valid_q;
  assign sweep_last  = (sweep_addr_q == gcd_pkg::CellAw'(gcd_pkg::Cells - 1));

  // Next state: sweep after reset and after the frame tag wraps
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcd_pkg::StSweep: if (sweep_last) state_d = gcd_pkg::StRun;
      gcd_pkg::StRun:   if (wrap) state_d = gcd_pkg::StSweep;
      default:          state_d = gcd_pkg::StSweep;
    endcase
  end

  // Memory write port and status outputs per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_q;
    ram_wdata = wdata_upd;
    stat_o    = '{s1_valid: s1_valid_q, block: wrap};
    case (state_q)
      gcd_pkg::StSweep: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_q;
        ram_wdata = '0;
        stat_o    = '{s1_valid: s1_valid_q, block: 1'b1};
      end
      gcd_pkg::StRun: begin
        ram_we = upd_we;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gcd_pkg::StSweep;
      sweep_addr_q <= '0;
      s1_valid_q   <= 1'b0;
      epoch_q      <= '0;
      count_q      <= '0;
      halt_q       <= 1'b0;
      fwd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= accept_i;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      halt_q      <= halt_d;
      fwd_valid_q <= upd_we;
      if (state_q == gcd_pkg::StSweep) begin
        sweep_addr_q <= sweep_last ? '0 : sweep_addr_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
      s1_addr_q <= raddr;
    end
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= wdata_upd;
  end

  // Halt holds until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  // No request taken and none in flight while the grid is swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == gcd_pkg::StSweep) |-> (!accept_i && !s1_valid_q))
    else $error("request overlaps grid sweep");

  // Collision count never goes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   s1_valid_q |=> (count_q >= $past(count_q)))
    else $error("collision count decreased");

  // A halted block writes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni) halt_q |-> !upd_we)
    else $error("grid written while halted");

endmodule

// File: sv/gcd_out_buf.sv
// ----------------------------------------------------------------------------
// gcd_out_buf: two-entry result buffer
// Holds finished results so the update stage never waits on the receiver.
// ----------------------------------------------------------------------------
module gcd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gcd_pkg::res_t push_data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output gcd_pkg::res_t data_o,
  output logic [1:0]    count_o
);

  gcd_pkg::res_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/grid_collision_detector.sv
// ----------------------------------------------------------------------------
// grid_collision_detector: occupancy-grid collision detector
// Looks up each drone report in a 16x16x16 grid and flags collisions.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item: a position report or an end of
//   frame (tuser bit 0). m_axis returns exactly one result per request.
//   cfg_* writes the collision limit; write it only while the block is idle.
// Timing:
//   One request per cycle while s_axis_tready is high; the result is pushed into
//   the output buffer in the cycle after acceptance (the cell read returns, then
//   update and write back in that cycle) and is offered on m_axis once the buffer
//   holds it. Back-to-back reports to the same cell are served by forwarding the
//   last write. The rate is set by the single read port of the grid RAM.
// Reset and frames:
//   After reset the grid RAM's 4096 cells are swept clear with s_axis_tready
//   low. End of frame bumps an 8-bit frame tag; every 256th frame end the tag
//   wraps and the same sweep runs again.
// Stall:
//   A two-entry output buffer absorbs results; s_axis_tready drops during a tag
//   wrap or sweep, else only when the buffer and the item in flight would overflow.
// ----------------------------------------------------------------------------
module grid_collision_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // drone_id[7:0], pos_x[11:8], pos_y[15:12],
                                     // pos_z[19:16], zero[23:20]
  input  logic [1:0]  s_axis_tuser,  // command[0], has_position[1]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // collision[0], other_drone[8:1],
                                     // collision_count[24:9], halted[25], zero[31:26]
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [gcd_pkg::CountW-1:0] limit_q;
  gcd_pkg::item_t             item;
  gcd_pkg::res_t              res, buf_res;
  gcd_pkg::stat_t             stat;
  logic                       res_valid, accept, pop;
  logic [1:0]                 buf_count;
  logic [2:0]                 inflight;

  // Unpack the request
  always_comb begin
    item.command      = s_axis_tuser[0];
    item.has_position = s_axis_tuser[1];
    item.drone_id     = s_axis_tdata[7:0];
    item.pos_x        = s_axis_tdata[11:8];
    item.pos_y        = s_axis_tdata[15:12];
    item.pos_z        = s_axis_tdata[19:16];
  end

  // Accept while no sweep or tag wrap and the buffer has room for everything in flight
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign inflight      = {1'b0, buf_count} + {2'b0, stat.s1_valid} - {2'b0, pop};
  assign s_axis_tready = !stat.block && (inflight <= 3'd1);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Collision limit register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= gcd_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  gcd_rmw u_rmw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .limit_i    (limit_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .stat_o     (stat)
  );

  gcd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (buf_res),
    .count_o    (buf_count)
  );

  // Pack the result
  assign m_axis_tdata = {6'b0, buf_res.halted, buf_res.collision_count,
                         buf_res.other_drone, buf_res.collision};

endmodule
